@@ rtl/mpe_pkg.sv @@
// mpe_pkg: kind codes, MessagePack tag bytes and the queue entry type
// shared by the scalar/header encoder modules. No dependencies.
package mpe_pkg;

    // input kind codes
    localparam logic [3:0] OP_NIL   = 4'd0;
    localparam logic [3:0] OP_TRUE  = 4'd1;
    localparam logic [3:0] OP_FALSE = 4'd2;
    localparam logic [3:0] OP_ARR   = 4'd3;
    localparam logic [3:0] OP_MAP   = 4'd4;
    localparam logic [3:0] OP_STR   = 4'd5;
    localparam logic [3:0] OP_UINT  = 4'd6;
    localparam logic [3:0] OP_SINT  = 4'd7;
    localparam logic [3:0] OP_RAW   = 4'd8;

    // tag bytes
    localparam logic [7:0] TAG_NIL    = 8'hc0;
    localparam logic [7:0] TAG_FALSE  = 8'hc2;
    localparam logic [7:0] TAG_TRUE   = 8'hc3;
    localparam logic [7:0] TAG_FIXARR = 8'h90;
    localparam logic [7:0] TAG_FIXMAP = 8'h80;
    localparam logic [7:0] TAG_FIXSTR = 8'ha0;
    localparam logic [7:0] TAG_STR8   = 8'hd9;
    localparam logic [7:0] TAG_STR16  = 8'hda;
    localparam logic [7:0] TAG_STR32  = 8'hdb;
    localparam logic [7:0] TAG_ARR16  = 8'hdc;
    localparam logic [7:0] TAG_ARR32  = 8'hdd;
    localparam logic [7:0] TAG_MAP16  = 8'hde;
    localparam logic [7:0] TAG_MAP32  = 8'hdf;
    localparam logic [7:0] TAG_U8     = 8'hcc;
    localparam logic [7:0] TAG_U16    = 8'hcd;
    localparam logic [7:0] TAG_U32    = 8'hce;
    localparam logic [7:0] TAG_I8     = 8'hd0;
    localparam logic [7:0] TAG_I16    = 8'hd1;
    localparam logic [7:0] TAG_I32    = 8'hd2;

    // one classified item: tag byte, payload left-aligned (first byte in
    // [31:24]) and number of payload bytes after the tag (0, 1, 2 or 4)
    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] pay;
        logic [2:0]  npay;
    } t_cmd;

endpackage

@@ rtl/mpe_ifs.sv @@
// mpe_in_if / mpe_out_if: valid/ready channels of the encoder.
// Depends on nothing.
interface mpe_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/mpe_front.sv @@
// mpe_front: accepts input beats and classifies each into tag, aligned
// payload and payload length. Depends on mpe_pkg and mpe_in_if.
module mpe_front (
    mpe_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output mpe_pkg::t_cmd   o_cmd
);
    import mpe_pkg::*;

    logic [31:0] v;
    logic        known;

    assign v = i_in.value;

    always_comb begin
        o_cmd = '{tag: TAG_NIL, pay: 32'd0, npay: 3'd0};
        known = 1'b1;
        case (i_in.op)
            OP_NIL:   o_cmd.tag = TAG_NIL;
            OP_TRUE:  o_cmd.tag = TAG_TRUE;
            OP_FALSE: o_cmd.tag = TAG_FALSE;
            OP_ARR, OP_MAP: begin
                if (v < 32'd16) begin
                    o_cmd.tag = ((i_in.op == OP_ARR) ? TAG_FIXARR : TAG_FIXMAP) | v[7:0];
                end else if (v < 32'h10000) begin
                    o_cmd.tag  = (i_in.op == OP_ARR) ? TAG_ARR16 : TAG_MAP16;
                    o_cmd.pay  = {v[15:0], 16'd0};
                    o_cmd.npay = 3'd2;
                end else begin
                    o_cmd.tag  = (i_in.op == OP_ARR) ? TAG_ARR32 : TAG_MAP32;
                    o_cmd.pay  = v;
                    o_cmd.npay = 3'd4;
                end
            end
            OP_STR: begin
                if (v < 32'd32) begin
                    o_cmd.tag = TAG_FIXSTR | v[7:0];
                end else if (v < 32'h100) begin
                    o_cmd.tag  = TAG_STR8;
                    o_cmd.pay  = {v[7:0], 24'd0};
                    o_cmd.npay = 3'd1;
                end else if (v < 32'h10000) begin
                    o_cmd.tag  = TAG_STR16;
                    o_cmd.pay  = {v[15:0], 16'd0};
                    o_cmd.npay = 3'd2;
                end else begin
                    o_cmd.tag  = TAG_STR32;
                    o_cmd.pay  = v;
                    o_cmd.npay = 3'd4;
                end
            end
            OP_UINT, OP_SINT: begin
                if (i_in.op == OP_SINT && v[31]) begin
                    if (v >= 32'hffffffe0) begin
                        o_cmd.tag = v[7:0];
                    end else if (v >= 32'hffffff80) begin
                        o_cmd.tag  = TAG_I8;
                        o_cmd.pay  = {v[7:0], 24'd0};
                        o_cmd.npay = 3'd1;
                    end else if (v >= 32'hffff8000) begin
                        o_cmd.tag  = TAG_I16;
                        o_cmd.pay  = {v[15:0], 16'd0};
                        o_cmd.npay = 3'd2;
                    end else begin
                        o_cmd.tag  = TAG_I32;
                        o_cmd.pay  = v;
                        o_cmd.npay = 3'd4;
                    end
                end else if (v < 32'h80) begin
                    o_cmd.tag = v[7:0];
                end else if (v < 32'h100) begin
                    o_cmd.tag  = TAG_U8;
                    o_cmd.pay  = {v[7:0], 24'd0};
                    o_cmd.npay = 3'd1;
                end else if (v < 32'h10000) begin
                    o_cmd.tag  = TAG_U16;
                    o_cmd.pay  = {v[15:0], 16'd0};
                    o_cmd.npay = 3'd2;
                end else begin
                    o_cmd.tag  = TAG_U32;
                    o_cmd.pay  = v;
                    o_cmd.npay = 3'd4;
                end
            end
            OP_RAW:  o_cmd.tag = v[7:0];
            default: known = 1'b0;
        endcase
    end

    // unknown kinds are taken and dropped
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && known;

endmodule

@@ rtl/mpe_queue.sv @@
// mpe_queue: two-entry queue of classified items between front and back.
// Depends on mpe_pkg.
module mpe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpe_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output mpe_pkg::t_cmd   o_cmd,
    output logic            o_full,
    output logic            o_empty
);
    import mpe_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    assign o_cmd   = r_mem[r_rptr];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

@@ rtl/mpe_back.sv @@
// mpe_back: serializes one queued item per run, tag then payload bytes,
// through a registered output stage. Depends on mpe_pkg and mpe_out_if.
module mpe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mpe_pkg::t_cmd   i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    mpe_out_if.source       o_out
);
    import mpe_pkg::*;

    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [31:0] r_pay;
    logic [2:0]  r_rem;
    logic        adv;

    assign adv   = !r_valid || o_out.ready;
    assign o_pop = adv && (r_rem == 3'd0) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= 3'd0;
        end else if (adv) begin
            if (r_rem != 3'd0) begin
                r_valid <= 1'b1;
                r_rem   <= r_rem - 3'd1;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_rem   <= i_cmd.npay;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload shifts out most significant byte first
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_rem != 3'd0) begin
                r_byte <= r_pay[31:24];
                r_last <= (r_rem == 3'd1);
                r_pay  <= {r_pay[23:0], 8'd0};
            end else if (!i_empty) begin
                r_byte <= i_cmd.tag;
                r_last <= (i_cmd.npay == 3'd0);
                r_pay  <= i_cmd.pay;
            end
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

@@ rtl/messagepack_scalar_header_encoder.sv @@
// Channel  | Dir | Fields                  | Beat
// i_in     | in  | op[3:0], value[31:0]    | one item to encode
// o_out    | out | out_byte[7:0], last     | one encoded byte
//
// Each item yields 1 to 5 output beats, one per cycle while o_out.ready holds;
// the back end's single byte lane serializes one item at a time.
// Items pass through a two-entry queue, then the registered output stage; the
// queue decouples front from back, so i_in.ready drops only when it is full.
// Unused kinds (9 to 15) are accepted and produce no bytes.
// i_rst_n is synchronous, active low, and empties the queue and output stage.
// Depends on mpe_pkg, mpe_ifs, mpe_front, mpe_queue, mpe_back.
module messagepack_scalar_header_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpe_in_if.sink      i_in,
    mpe_out_if.source   o_out
);
    import mpe_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    mpe_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    mpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    mpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ rtl/mpe_checker.sv @@
// mpe_checker: port-level checks on the encoder, bound to the top level.
// Depends on mpe_pkg.
module mpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [3:0]  i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_last
);
    import mpe_pkg::*;

    logic [3:0] r_open;
    logic [2:0] r_run;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready && (i_in_op <= OP_RAW);
    assign out_beat = i_out_valid && i_out_ready;

    // items accepted whose last byte has not gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 4'd0;
            r_run  <= 3'd0;
        end else begin
            r_open <= r_open + {3'd0, in_beat} - {3'd0, out_beat && i_out_last};
            if (out_beat) r_run <= i_out_last ? 3'd0 : r_run + 3'd1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 4'd0)
        else $error("output byte without an open item");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && !i_out_last) |-> r_run < 3'd4)
        else $error("item run longer than five bytes");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("stalled output beat changed");

endmodule

bind messagepack_scalar_header_encoder mpe_checker u_mpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

@@ tb/sv/messagepack_scalar_header_encoder_test.sv @@
// Testbench for messagepack_scalar_header_encoder: predicts the encoded byte run of
// every accepted item and checks each output beat in order.
// Depends on mpe_pkg, mpe_ifs and the encoder RTL.
`timescale 1ns / 1ps

module messagepack_scalar_header_encoder_test;
    import mpe_pkg::*;

    localparam int IDLE_PCT      = 26;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_ITEMS  = 360;
    localparam int HOLD_AT_BEAT  = 120;
    localparam int HOLD_CYCLES   = 80;
    localparam logic [3:0] OP_UNUSED_LO = OP_RAW + 4'd1;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] value;
        bit          wait_drain;
    } t_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_beat;

    logic clk;
    logic rst_n;

    mpe_in_if  in_ch ();
    mpe_out_if out_ch ();

    messagepack_scalar_header_encoder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_item pending_q[$];
    t_beat byte_q[$];
    t_item next_item;
    t_beat want;
    int    errors     = 0;
    int    sent_cnt   = 0;
    int    beats_seen = 0;
    int    hold_left  = 0;
    int    quiet_cyc  = 0;

    // ---------------- expected byte runs ----------------

    function automatic void push_run(input logic [7:0] tag, input logic [31:0] pay,
                                     input int nbytes);
        t_beat b;
        b.data = tag;
        b.last = (nbytes == 0);
        byte_q.push_back(b);
        for (int i = nbytes - 1; i >= 0; i--) begin
            b.data = pay[8*i +: 8];
            b.last = (i == 0);
            byte_q.push_back(b);
        end
    endfunction

    function automatic void push_uint(input logic [31:0] v);
        if (v < 32'h80)         push_run(v[7:0], '0, 0);
        else if (v < 32'h100)   push_run(TAG_U8, v, 1);
        else if (v < 32'h10000) push_run(TAG_U16, v, 2);
        else                    push_run(TAG_U32, v, 4);
    endfunction

    function automatic void push_header(input logic [31:0] n, input logic [7:0] fixbase,
                                        input logic [7:0] tag16, input logic [7:0] tag32);
        if (n < 32'd16)         push_run(fixbase | n[7:0], '0, 0);
        else if (n < 32'h10000) push_run(tag16, n, 2);
        else                    push_run(tag32, n, 4);
    endfunction

    function automatic void predict_bytes(input logic [3:0] op, input logic [31:0] v);
        case (op)
            OP_NIL:   push_run(TAG_NIL, '0, 0);
            OP_TRUE:  push_run(TAG_TRUE, '0, 0);
            OP_FALSE: push_run(TAG_FALSE, '0, 0);
            OP_ARR:   push_header(v, TAG_FIXARR, TAG_ARR16, TAG_ARR32);
            OP_MAP:   push_header(v, TAG_FIXMAP, TAG_MAP16, TAG_MAP32);
            OP_STR: begin
                if (v < 32'd32)         push_run(TAG_FIXSTR | v[7:0], '0, 0);
                else if (v < 32'h100)   push_run(TAG_STR8, v, 1);
                else if (v < 32'h10000) push_run(TAG_STR16, v, 2);
                else                    push_run(TAG_STR32, v, 4);
            end
            OP_UINT:  push_uint(v);
            OP_SINT: begin
                if (!v[31])                  push_uint(v);
                else if (v >= 32'hffffffe0)  push_run(v[7:0], '0, 0);
                else if (v >= 32'hffffff80)  push_run(TAG_I8, v, 1);
                else if (v >= 32'hffff8000)  push_run(TAG_I16, v, 2);
                else                         push_run(TAG_I32, v, 4);
            end
            OP_RAW:   push_run(v[7:0], '0, 0);
            default: ;  // unused kinds produce nothing
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void add_item(input logic [3:0] op, input logic [31:0] v,
                                     input bit drain = 1'b0);
        t_item it;
        it.op         = op;
        it.value      = v;
        it.wait_drain = drain;
        pending_q.push_back(it);
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 19))
            0:  return 32'h0;
            1:  return 32'hf;
            2:  return 32'h10;
            3:  return 32'h1f;
            4:  return 32'h20;
            5:  return 32'h7f;
            6:  return 32'h80;
            7:  return 32'hff;
            8:  return 32'h100;
            9:  return 32'hffff;
            10: return 32'h10000;
            11: return 32'hffffffff;
            12: return 32'h80000000;
            13: return 32'h7fffffff;
            14: return 32'hffffffe0;
            15: return 32'hffffffdf;
            16: return 32'hffffff80;
            17: return 32'hffffff7f;
            18: return 32'hffff8000;
            default: return 32'hffff7fff;
        endcase
    endfunction

    // spread values over every encoding width
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 31);
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 65535);
            3: return $urandom;
            4: return edge_value();
            default: return 32'hffffffff - $urandom_range(0, 40000);
        endcase
    endfunction

    function automatic logic [3:0] rand_scalar_op();
        if ($urandom_range(0, 99) < 5) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        return 4'($urandom_range(OP_NIL, OP_RAW));
    endfunction

    function automatic bit send_gap();
        if (sent_cnt >= 200 && sent_cnt < 280) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic bit recv_gap();
        if (beats_seen >= 500 && beats_seen < 750) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // ---------------- clock ----------------

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- driver ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_bytes(in_ch.op, in_ch.value);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && !send_gap() &&
                    (!pending_q[0].wait_drain || byte_q.size() == 0)) begin
                    next_item = pending_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op    <= next_item.op;
                    in_ch.value <= next_item.value;
                    sent_cnt++;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                beats_seen++;
                if (byte_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got byte %02h last %0b",
                             $time, out_ch.out_byte, out_ch.last);
                    errors++;
                end else begin
                    want = byte_q.pop_front();
                    if (out_ch.out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, out_ch.out_byte);
                        errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, out_ch.last);
                        errors++;
                    end
                end
                // back-pressure: hold off long enough to fill the block
                if (beats_seen == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !recv_gap();
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cyc = 0;
            end else begin
                quiet_cyc++;
            end
            if (quiet_cyc >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cyc);
                $display("messagepack_scalar_header_encoder_test: FAIL");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int      n;
        int      r;
        int      count;
        bit      first;
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_NIL;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;

        // directed: width boundaries of every kind
        add_item(OP_NIL, 32'h0);
        add_item(OP_TRUE, 32'hffffffff);
        add_item(OP_FALSE, 32'h0);
        add_item(OP_ARR, 32'hf);
        add_item(OP_ARR, 32'h10);
        add_item(OP_ARR, 32'h10000);
        add_item(OP_MAP, 32'hffff);
        add_item(OP_MAP, 32'hffffffff);
        add_item(OP_STR, 32'h1f);
        add_item(OP_STR, 32'h20);
        add_item(OP_STR, 32'hff);
        add_item(OP_STR, 32'h100);
        add_item(OP_STR, 32'h10000);
        add_item(OP_UINT, 32'h7f);
        add_item(OP_UINT, 32'h80);
        add_item(OP_UINT, 32'hffff);
        add_item(OP_UINT, 32'hffffffff);
        add_item(OP_SINT, 32'hffffffe0);
        add_item(OP_SINT, 32'hffffffdf);
        add_item(OP_SINT, 32'hffffff80);
        add_item(OP_SINT, 32'hffff7fff);
        add_item(OP_SINT, 32'h80000000);
        add_item(OP_SINT, 32'h80);       // positive signed takes the unsigned forms
        add_item(OP_RAW, 32'hfedcba98);  // only the low byte goes out
        add_item(OP_UNUSED_LO, 32'h12345678);
        add_item(OP_UNUSED_HI, 32'hffffffff);

        // random: mostly framed strings, arrays and maps, the rest loose scalars
        count = 0;
        first = 1'b1;
        while (count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                n = (r < 3) ? $urandom_range(32, 40) : $urandom_range(0, 12);
                add_item(OP_STR, n, first);
                for (int i = 0; i < n; i++) add_item(OP_RAW, $urandom);
                count += n + 1;
            end else if (r < 40) begin
                n = $urandom_range(0, 17);
                add_item($urandom_range(0, 1) ? OP_ARR : OP_MAP, n, first);
                for (int i = 0; i < n; i++) add_item(rand_scalar_op(), rand_value());
                count += n + 1;
            end else begin
                add_item(rand_scalar_op(), rand_value(), first);
                count++;
            end
            first = 1'b0;
            // pause the sender again midway until the output drains
            if (count >= RANDOM_ITEMS / 2 && count < RANDOM_ITEMS / 2 + 20) first = 1'b1;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_ch.valid || byte_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (byte_q.size() != 0) begin
            $display("%0t: %0d expected beats never arrived, next expected byte %02h",
                     $time, byte_q.size(), byte_q[0].data);
            errors++;
        end
        if (errors == 0) begin
            $display("messagepack_scalar_header_encoder_test: PASS");
        end else begin
            $display("messagepack_scalar_header_encoder_test: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mpe_pkg.sv
rtl/mpe_ifs.sv
rtl/mpe_front.sv
rtl/mpe_queue.sv
rtl/mpe_back.sv
rtl/messagepack_scalar_header_encoder.sv
rtl/mpe_checker.sv
tb/sv/messagepack_scalar_header_encoder_test.sv
